>>> rtl/core/sgr_pkg.sv
// shared types and constants for the sgr attribute tracker
`default_nettype none
package sgr_pkg;
   localparam logic [20:0] CH_ESC  = 21'd27;
   localparam logic [20:0] CH_LBR  = 21'd91;
   localparam logic [20:0] CH_SEMI = 21'd59;
   localparam logic [20:0] CH_M    = 21'd109;
   localparam logic [20:0] CH_ZERO = 21'd48;
   localparam logic [20:0] CH_NINE = 21'd57;

   localparam logic [1:0] REG_IGNORE = 2'd0;
   localparam logic [1:0] REG_DEF_FG = 2'd1;
   localparam logic [1:0] REG_DEF_BG = 2'd2;

   typedef enum logic [1:0] {
      MODE_PLAIN,
      MODE_REGION,
      MODE_ESC,
      MODE_ARGS
   } mode_type;

   // work queued from the front to the back
   typedef enum logic [1:0] {
      OP_EMIT,
      OP_APPLY,
      OP_RESET
   } op_type;

   typedef struct packed {
      op_type      op;
      logic [20:0] ch;
      logic [6:0]  nargs;
      logic        last;
   } cmd_type;

   typedef enum logic [1:0] {
      BK_IDLE,
      BK_FETCH,
      BK_EXEC
   } bk_state_type;
endpackage
`default_nettype wire

>>> rtl/core/sgr_escape_attribute_tracker.sv
// top level: csr block, front end, command queue and back end
//
// channel | direction | handshake          | payload
// req     | in        | req_valid/req_stall| char_code, last_of_prompt
// rsp     | out       | rsp_valid/rsp_stall| out_char, attributes, colours
// csr     | in        | apb, pready high   | ignore_char, default_fg, default_bg
//
// visible characters and the last of a prompt pass a command to the back end;
// a closing m passes one too and holds the input while the back end walks
// the stored arguments through the single read port of the argument store.
// reset is synchronous and returns to plain text with default colours.
// req_stall is high while the queue holds a transaction or an argument walk runs.
`default_nettype none
module sgr_escape_attribute_tracker #(
   parameter int MAX_ARGS = 32,
   parameter int ARG_BITS = 16
) (
   input  wire         clock,
   input  wire         reset,
   input  wire         req_valid,
   output logic        req_stall,
   input  wire  [20:0] req_char_code,
   input  wire         req_last_of_prompt,
   output logic        rsp_valid,
   input  wire         rsp_stall,
   output logic [20:0] rsp_out_char,
   output logic        rsp_bold,
   output logic        rsp_italic,
   output logic        rsp_underline,
   output logic        rsp_blink,
   output logic        rsp_inverse,
   output logic signed [8:0] rsp_fg_color,
   output logic signed [8:0] rsp_bg_color,
   input  wire         csr_psel,
   input  wire         csr_penable,
   input  wire         csr_pwrite,
   input  wire  [3:0]  csr_paddr,
   input  wire  [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);
   localparam int AW = $clog2(MAX_ARGS);
   logic [20:0] ignore_ff;
   logic [8:0] dfg_ff, dbg_ff;
   logic [1:0] ridx;
   logic back_busy, cmd_valid, cmd_full, q_valid, q_take;
   sgr_pkg::cmd_type cmd, q_cmd;
   logic [AW-1:0] rd_addr;
   logic [ARG_BITS-1:0] rd_data;
   logic [4:0] flags;
   logic [8:0] fg, bg;

   assign csr_pready = 1'b1;
   assign ridx = csr_paddr[3:2];
   always_ff @(posedge clock) begin
      if (reset) begin
         ignore_ff <= '0;
         dfg_ff <= 9'h1FF;
         dbg_ff <= 9'h1FF;
      end else if (csr_psel && csr_penable && csr_pwrite) begin
         case (ridx)
            sgr_pkg::REG_IGNORE: ignore_ff <= csr_pwdata[20:0];
            sgr_pkg::REG_DEF_FG: dfg_ff <= csr_pwdata[8:0];
            sgr_pkg::REG_DEF_BG: dbg_ff <= csr_pwdata[8:0];
            default: ;
         endcase
      end
   end
   always_comb begin
      case (ridx)
         sgr_pkg::REG_IGNORE: csr_prdata = {11'd0, ignore_ff};
         sgr_pkg::REG_DEF_FG: csr_prdata = {{23{dfg_ff[8]}}, dfg_ff};
         sgr_pkg::REG_DEF_BG: csr_prdata = {{23{dbg_ff[8]}}, dbg_ff};
         default: csr_prdata = '0;
      endcase
   end

   sgr_front #(.MAX_ARGS(MAX_ARGS), .ARG_BITS(ARG_BITS)) u_front (
      .clock, .reset, .in_valid(req_valid), .in_stall(req_stall),
      .in_char(req_char_code), .in_last(req_last_of_prompt),
      .ignore_char(ignore_ff), .back_busy, .cmd_valid, .cmd_full, .cmd,
      .rd_addr, .rd_data);

   sgr_queue u_queue (
      .clock, .reset, .wr_valid(cmd_valid), .wr_cmd(cmd), .full(cmd_full),
      .rd_valid(q_valid), .rd_take(q_take), .rd_cmd(q_cmd));

   sgr_back #(.MAX_ARGS(MAX_ARGS), .ARG_BITS(ARG_BITS)) u_back (
      .clock, .reset, .q_valid, .q_take, .q_cmd, .busy(back_busy),
      .rd_addr, .rd_data, .default_fg(dfg_ff), .default_bg(dbg_ff),
      .out_valid(rsp_valid), .out_stall(rsp_stall), .out_char(rsp_out_char),
      .out_flags(flags), .out_fg(fg), .out_bg(bg));

   assign rsp_bold = flags[0];
   assign rsp_italic = flags[1];
   assign rsp_underline = flags[2];
   assign rsp_blink = flags[3];
   assign rsp_inverse = flags[4];
   assign rsp_fg_color = fg;
   assign rsp_bg_color = bg;
endmodule
`default_nettype wire

>>> rtl/core/sgr_front.sv
// front end: scans characters, parses arguments into the store, queues commands
`default_nettype none
module sgr_front #(
   parameter int MAX_ARGS = 32,
   parameter int ARG_BITS = 16,
   localparam int AW = $clog2(MAX_ARGS),
   localparam int CW = $clog2(MAX_ARGS + 1)
) (
   input  wire                   clock,
   input  wire                   reset,
   input  wire                   in_valid,
   output logic                  in_stall,
   input  wire  [20:0]           in_char,
   input  wire                   in_last,
   input  wire  [20:0]           ignore_char,
   input  wire                   back_busy,
   output logic                  cmd_valid,
   input  wire                   cmd_full,
   output sgr_pkg::cmd_type      cmd,
   input  wire  [AW-1:0]         rd_addr,
   output logic [ARG_BITS-1:0]   rd_data
);
   localparam logic [ARG_BITS-1:0] ARG_MAX = {ARG_BITS{1'b1}};

   logic [ARG_BITS-1:0] store_mem [MAX_ARGS];
   sgr_pkg::mode_type mode_ff, mode_in;
   logic [CW-1:0] count_ff, count_in;
   logic [ARG_BITS-1:0] cur_ff, cur_in;
   logic wr_en;
   logic [AW-1:0] wr_addr;
   logic [ARG_BITS-1:0] wr_data;
   logic fence, is_digit, acc;
   logic [ARG_BITS+3:0] prod;
   logic [CW-1:0] count_m1;

   // the store is read by the back end while a sequence is applied, so hold
   // new characters while the back end or queue is busy
   assign in_stall = back_busy || cmd_full;
   assign acc = in_valid && !in_stall;
   assign fence = (ignore_char != '0) && (in_char == ignore_char);
   assign is_digit = (in_char >= sgr_pkg::CH_ZERO) && (in_char <= sgr_pkg::CH_NINE);
   assign prod = ({4'd0, cur_ff} << 3) + ({4'd0, cur_ff} << 1)
                 + (ARG_BITS+4)'(in_char[3:0]);
   assign count_m1 = count_ff - CW'(1);

   always_comb begin
      mode_in = mode_ff;
      count_in = count_ff;
      cur_in = cur_ff;
      wr_en = 1'b0;
      wr_addr = count_m1[AW-1:0];
      wr_data = cur_ff;
      cmd_valid = 1'b0;
      cmd.op = sgr_pkg::OP_RESET;
      cmd.ch = in_char;
      cmd.nargs = 7'(count_ff);
      cmd.last = in_last;
      if (acc) begin
         if (mode_ff == sgr_pkg::MODE_PLAIN) begin
            if (fence) mode_in = sgr_pkg::MODE_REGION;
            else begin
               cmd_valid = 1'b1;
               cmd.op = sgr_pkg::OP_EMIT;
            end
         end else if (fence) begin
            mode_in = sgr_pkg::MODE_PLAIN;
         end else begin
            unique case (mode_ff)
               sgr_pkg::MODE_ESC: begin
                  if (in_char == sgr_pkg::CH_LBR) begin
                     mode_in = sgr_pkg::MODE_ARGS;
                     count_in = CW'(1);
                     cur_in = '0;
                  end else if (in_char != sgr_pkg::CH_ESC) mode_in = sgr_pkg::MODE_REGION;
               end
               sgr_pkg::MODE_ARGS: begin
                  if (is_digit) begin
                     cur_in = (prod > (ARG_BITS+4)'(ARG_MAX)) ? ARG_MAX
                                                            : prod[ARG_BITS-1:0];
                  end else if (in_char == sgr_pkg::CH_SEMI) begin
                     if (count_ff >= CW'(MAX_ARGS)) mode_in = sgr_pkg::MODE_REGION;
                     else begin
                        wr_en = 1'b1;
                        count_in = count_ff + CW'(1);
                        cur_in = '0;
                     end
                  end else begin
                     mode_in = sgr_pkg::MODE_REGION;
                     if (in_char == sgr_pkg::CH_M) begin
                        wr_en = 1'b1;
                        cmd_valid = 1'b1;
                        cmd.op = sgr_pkg::OP_APPLY;
                     end
                  end
               end
               default: begin
                  if (in_char == sgr_pkg::CH_ESC) mode_in = sgr_pkg::MODE_ESC;
               end
            endcase
         end
         if (in_last) begin
            mode_in = sgr_pkg::MODE_PLAIN;
            count_in = '0;
            if (!cmd_valid) begin
               cmd_valid = 1'b1;
               cmd.op = sgr_pkg::OP_RESET;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= sgr_pkg::MODE_PLAIN;
         count_ff <= '0;
      end else begin
         mode_ff <= mode_in;
         count_ff <= count_in;
      end
      cur_ff <= cur_in;
   end

   always_ff @(posedge clock) begin
      if (wr_en) store_mem[wr_addr] <= wr_data;
      rd_data <= store_mem[rd_addr];
   end
endmodule
`default_nettype wire

>>> rtl/core/sgr_queue.sv
// two-entry command queue between front and back
`default_nettype none
module sgr_queue (
   input  wire              clock,
   input  wire              reset,
   input  wire              wr_valid,
   input  sgr_pkg::cmd_type wr_cmd,
   output logic             full,
   output logic             rd_valid,
   input  wire              rd_take,
   output sgr_pkg::cmd_type rd_cmd
);
   sgr_pkg::cmd_type slot_ff [2];
   logic [1:0] cnt_ff;
   logic rp_ff, wp_ff;
   logic do_wr, do_rd;

   assign full = cnt_ff == 2'd2;
   assign rd_valid = cnt_ff != 2'd0;
   assign rd_cmd = slot_ff[rp_ff];
   assign do_wr = wr_valid && !full;
   assign do_rd = rd_take && rd_valid;

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
         rp_ff <= 1'b0;
         wp_ff <= 1'b0;
      end else begin
         cnt_ff <= cnt_ff + 2'(do_wr) - 2'(do_rd);
         if (do_wr) wp_ff <= !wp_ff;
         if (do_rd) rp_ff <= !rp_ff;
      end
      if (do_wr) slot_ff[wp_ff] <= wr_cmd;
   end
endmodule
`default_nettype wire

>>> rtl/core/sgr_back.sv
// back end: applies argument lists, keeps rendition, drives result register
`default_nettype none
module sgr_back #(
   parameter int MAX_ARGS = 32,
   parameter int ARG_BITS = 16,
   localparam int AW = $clog2(MAX_ARGS)
) (
   input  wire                  clock,
   input  wire                  reset,
   input  wire                  q_valid,
   output logic                 q_take,
   input  sgr_pkg::cmd_type     q_cmd,
   output logic                 busy,
   output logic [AW-1:0]        rd_addr,
   input  wire  [ARG_BITS-1:0]  rd_data,
   input  wire  [8:0]           default_fg,
   input  wire  [8:0]           default_bg,
   output logic                 out_valid,
   input  wire                  out_stall,
   output logic [20:0]          out_char,
   output logic [4:0]           out_flags,
   output logic [8:0]           out_fg,
   output logic [8:0]           out_bg
);
   sgr_pkg::bk_state_type st_ff, st_in;
   logic [4:0] flags_ff, flags_in;
   logic [8:0] fg_ff, fg_in, bg_ff, bg_in;
   logic [6:0] idx_ff, idx_in, n_ff, n_in;
   logic [1:0] sub_ff, sub_in;   // 0 plain, 1 selector due, 2 colour due, 3 skip
   logic tgt_ff, tgt_in;         // 1 background
   logic [2:0] skip_ff, skip_in;
   logic last_ff, last_in;
   logic ov_ff, ov_in;
   logic can_out, stop, done;
   logic [ARG_BITS-1:0] a;

   assign busy = q_valid || (st_ff != sgr_pkg::BK_IDLE);
   assign can_out = !ov_ff || !out_stall;
   assign rd_addr = idx_ff[AW-1:0];
   assign a = rd_data;

   always_comb begin
      st_in = st_ff;
      unique case (st_ff)
         sgr_pkg::BK_IDLE:
            if (q_valid && q_cmd.op == sgr_pkg::OP_APPLY) st_in = sgr_pkg::BK_FETCH;
         sgr_pkg::BK_FETCH: st_in = sgr_pkg::BK_EXEC;
         sgr_pkg::BK_EXEC:  st_in = (stop || done) ? sgr_pkg::BK_IDLE : sgr_pkg::BK_FETCH;
         default: st_in = sgr_pkg::BK_IDLE;
      endcase
   end

   always_comb begin
      q_take = 1'b0;
      flags_in = flags_ff; fg_in = fg_ff; bg_in = bg_ff;
      idx_in = idx_ff; n_in = n_ff; sub_in = sub_ff; tgt_in = tgt_ff;
      skip_in = skip_ff; last_in = last_ff; ov_in = ov_ff && out_stall;
      stop = 1'b0; done = 1'b0;
      unique case (st_ff)
         sgr_pkg::BK_IDLE: begin
            if (q_valid && q_cmd.op == sgr_pkg::OP_APPLY) begin
               q_take = 1'b1;
               idx_in = '0; n_in = q_cmd.nargs; sub_in = 2'd0; last_in = q_cmd.last;
            end else if (q_valid && can_out) begin
               q_take = 1'b1;
               if (q_cmd.op == sgr_pkg::OP_EMIT) ov_in = 1'b1;
               if (q_cmd.last) begin
                  flags_in = '0; fg_in = default_fg; bg_in = default_bg;
               end
            end
         end
         sgr_pkg::BK_FETCH: ;
         sgr_pkg::BK_EXEC: begin
            idx_in = idx_ff + 7'd1;
            unique case (sub_ff)
               2'd1: begin
                  if (a == ARG_BITS'(2)) begin
                     if (tgt_ff) bg_in = 9'd1; else fg_in = 9'd1;
                     sub_in = 2'd3; skip_in = 3'd3;
                  end else if (a == ARG_BITS'(5)) sub_in = 2'd2;
                  else stop = 1'b1;
               end
               2'd2: begin
                  if (tgt_ff) bg_in = (a > ARG_BITS'(255)) ? 9'd255 : 9'(a[7:0]);
                  else fg_in = (a > ARG_BITS'(255)) ? 9'd255 : 9'(a[7:0]);
                  sub_in = 2'd0;
               end
               2'd3: begin
                  skip_in = skip_ff - 3'd1;
                  if (skip_ff == 3'd1) sub_in = 2'd0;
               end
               default: begin
                  if (a == '0) begin
                     flags_in = '0; fg_in = default_fg; bg_in = default_bg;
                  end else if (a == ARG_BITS'(1)) flags_in[0] = 1'b1;
                  else if (a == ARG_BITS'(3)) flags_in[1] = 1'b1;
                  else if (a == ARG_BITS'(4)) flags_in[2] = 1'b1;
                  else if (a == ARG_BITS'(5)) flags_in[3] = 1'b1;
                  else if (a == ARG_BITS'(7)) flags_in[4] = 1'b1;
                  else if (a == ARG_BITS'(2) || a == ARG_BITS'(6)
                           || (a >= ARG_BITS'(8) && a <= ARG_BITS'(20))
                           || a == ARG_BITS'(28) || a == ARG_BITS'(29)
                           || (a >= ARG_BITS'(51) && a <= ARG_BITS'(55))
                           || (a >= ARG_BITS'(60) && a <= ARG_BITS'(65))) ;
                  else if (a == ARG_BITS'(21) || a == ARG_BITS'(22)) flags_in[0] = 1'b0;
                  else if (a == ARG_BITS'(23)) flags_in[1] = 1'b0;
                  else if (a == ARG_BITS'(24)) flags_in[2] = 1'b0;
                  else if (a == ARG_BITS'(25)) flags_in[3] = 1'b0;
                  else if (a == ARG_BITS'(27)) flags_in[4] = 1'b0;
                  // 30 to 37 map to 0 to 7 by adding 2 to the low three bits
                  else if (a >= ARG_BITS'(30) && a <= ARG_BITS'(37))
                     fg_in = {6'd0, 3'(a[2:0] + 3'd2)};
                  else if (a >= ARG_BITS'(40) && a <= ARG_BITS'(47)) bg_in = 9'(a[2:0]);
                  else if (a == ARG_BITS'(38) || a == ARG_BITS'(48)) begin
                     // needs two more arguments before anything happens
                     if ({1'b0, idx_ff} + 8'd2 >= {1'b0, n_ff}) stop = 1'b1;
                     else begin
                        sub_in = 2'd1; tgt_in = a == ARG_BITS'(48);
                     end
                  end else stop = 1'b1;
               end
            endcase
            done = idx_in >= n_ff;
            if ((stop || done) && last_ff) begin
               flags_in = '0; fg_in = default_fg; bg_in = default_bg;
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff <= sgr_pkg::BK_IDLE;
         ov_ff <= 1'b0;
         flags_ff <= '0;
         fg_ff <= 9'h1FF;
         bg_ff <= 9'h1FF;
      end else begin
         st_ff <= st_in;
         ov_ff <= ov_in;
         flags_ff <= flags_in;
         fg_ff <= fg_in;
         bg_ff <= bg_in;
      end
      idx_ff <= idx_in; n_ff <= n_in; sub_ff <= sub_in; tgt_ff <= tgt_in;
      skip_ff <= skip_in; last_ff <= last_in;
      if (st_ff == sgr_pkg::BK_IDLE && q_valid && can_out
          && q_cmd.op == sgr_pkg::OP_EMIT) begin
         out_char <= q_cmd.ch;
         out_flags <= flags_ff;
         out_fg <= fg_ff;
         out_bg <= bg_ff;
      end
   end

   assign out_valid = ov_ff;
endmodule
`default_nettype wire

>>> rtl/core/sgr_checker.sv
// port-level checks for the tracker, bound to the top level
`default_nettype none
module sgr_checker (
   input wire        clock,
   input wire        reset,
   input wire        req_valid,
   input wire        req_stall,
   input wire        rsp_valid,
   input wire        rsp_stall,
   input wire [20:0] rsp_out_char,
   input wire        csr_pready
);
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_out_char))
      else $error("stalled result changed");
   a_pready: assert property (@(posedge clock) csr_pready)
      else $error("pready low");
   a_reset_idle: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result after reset");
   a_no_nul: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(req_valid) || $past(rsp_valid) || $past(req_stall))
      else $error("result without transaction");
endmodule
bind sgr_escape_attribute_tracker sgr_checker u_sgr_checker (
   .clock, .reset, .req_valid, .req_stall, .rsp_valid, .rsp_stall,
   .rsp_out_char, .csr_pready);
`default_nettype wire

>>> bench/tb_sgr_escape_attribute_tracker.sv
// testbench for the sgr attribute tracker: directed table, random prompts, scoreboard
`default_nettype none
module tb_sgr_escape_attribute_tracker;
   localparam int NARGS = 32;
   localparam int ARGMAX = 65535;
   localparam int N_RANDOM = 1200;

   typedef struct packed {
      logic [20:0] ch;
      logic        bold;
      logic        italic;
      logic        underline;
      logic        blink;
      logic        inverse;
      logic [8:0]  fg;
      logic [8:0]  bg;
   } glyph_type;

   typedef struct {
      logic [20:0] ch;
      logic        last;
      bit          typed;
      glyph_type   want;
   } row_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic [20:0] req_char_code = 21'd65;
   logic req_last_of_prompt = 1'b0;
   logic rsp_stall = 1'b0;
   logic csr_psel = 1'b0, csr_penable = 1'b0, csr_pwrite = 1'b0;
   logic [3:0] csr_paddr = 4'd0;
   logic [31:0] csr_pwdata = 32'd0;
   wire req_stall, rsp_valid, csr_pready;
   wire [31:0] csr_prdata;
   wire [20:0] rsp_out_char;
   wire rsp_bold, rsp_italic, rsp_underline, rsp_blink, rsp_inverse;
   wire signed [8:0] rsp_fg_color, rsp_bg_color;

   sgr_escape_attribute_tracker dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall),
      .req_char_code(req_char_code), .req_last_of_prompt(req_last_of_prompt),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall),
      .rsp_out_char(rsp_out_char), .rsp_bold(rsp_bold), .rsp_italic(rsp_italic),
      .rsp_underline(rsp_underline), .rsp_blink(rsp_blink), .rsp_inverse(rsp_inverse),
      .rsp_fg_color(rsp_fg_color), .rsp_bg_color(rsp_bg_color),
      .csr_psel(csr_psel), .csr_penable(csr_penable), .csr_pwrite(csr_pwrite),
      .csr_paddr(csr_paddr), .csr_pwdata(csr_pwdata), .csr_prdata(csr_prdata),
      .csr_pready(csr_pready)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   initial begin
      #60000000;
      $display("sgr_escape_attribute_tracker regression: fail");
      $finish;
   end

   // tracker shadow state
   logic [20:0] fence_ch;
   logic [8:0]  dflt_fg, dflt_bg;
   sgr_pkg::mode_type scan;
   int unsigned params[NARGS];
   int          nparams;
   logic [4:0]  flags;
   logic [8:0]  fg_now, bg_now;

   glyph_type   pending_glyphs[$];
   int          errors = 0;
   int          send_idle = 0, recv_idle = 0;

   task automatic report(input string what, input logic [31:0] got, input logic [31:0] exp);
      $display("mismatch %s: got %0h expected %0h at %0t", what, got, exp, $realtime);
      errors++;
   endtask

   function automatic void rendition_clear();
      flags = '0;
      fg_now = dflt_fg;
      bg_now = dflt_bg;
   endfunction

   function automatic void tracker_clear();
      scan = sgr_pkg::MODE_PLAIN;
      nparams = 0;
      rendition_clear();
   endfunction

   function automatic void apply_sgr();
      int i;
      int unsigned a;
      i = 0;
      while (i < nparams) begin
         a = params[i];
         if (a == 0) rendition_clear();
         else if (a == 1) flags[0] = 1'b1;
         else if (a == 3) flags[1] = 1'b1;
         else if (a == 4) flags[2] = 1'b1;
         else if (a == 5) flags[3] = 1'b1;
         else if (a == 7) flags[4] = 1'b1;
         else if (a == 2 || a == 6 || (a >= 8 && a <= 20) || a == 28 || a == 29 ||
                  (a >= 51 && a <= 55) || (a >= 60 && a <= 65)) begin
         end
         else if (a == 21 || a == 22) flags[0] = 1'b0;
         else if (a == 23) flags[1] = 1'b0;
         else if (a == 24) flags[2] = 1'b0;
         else if (a == 25) flags[3] = 1'b0;
         else if (a == 27) flags[4] = 1'b0;
         else if (a >= 30 && a <= 37) fg_now = 9'(a - 30);
         else if (a >= 40 && a <= 47) bg_now = 9'(a - 40);
         else if (a == 38 || a == 48) begin
            if (i + 2 >= nparams || (params[i+1] != 2 && params[i+1] != 5)) return;
            if (params[i+1] == 2) begin
               if (a == 38) fg_now = 9'd1; else bg_now = 9'd1;
               i += 4;
            end else begin
               if (a == 38) fg_now = params[i+2] > 255 ? 9'd255 : 9'(params[i+2]);
               else bg_now = params[i+2] > 255 ? 9'd255 : 9'(params[i+2]);
               i += 2;
            end
         end
         else return;
         i++;
      end
   endfunction

   // advances shadow state for one accepted transaction, queues any glyph
   function automatic void track_char(input logic [20:0] ch, input logic last);
      bit fence;
      int unsigned v;
      fence = fence_ch != 0 && ch == fence_ch;
      if (scan == sgr_pkg::MODE_PLAIN) begin
         if (fence) scan = sgr_pkg::MODE_REGION;
         else pending_glyphs.push_back({ch, flags[0], flags[1], flags[2], flags[3],
                                        flags[4], fg_now, bg_now});
      end else if (fence) scan = sgr_pkg::MODE_PLAIN;
      else if (scan == sgr_pkg::MODE_ESC) begin
         if (ch == sgr_pkg::CH_LBR) begin
            params[0] = 0;
            nparams = 1;
            scan = sgr_pkg::MODE_ARGS;
         end else if (ch != sgr_pkg::CH_ESC) scan = sgr_pkg::MODE_REGION;
      end else if (scan == sgr_pkg::MODE_ARGS) begin
         if (ch >= sgr_pkg::CH_ZERO && ch <= sgr_pkg::CH_NINE) begin
            v = params[nparams-1] * 10 + (ch - sgr_pkg::CH_ZERO);
            params[nparams-1] = v > ARGMAX ? ARGMAX : v;
         end else if (ch == sgr_pkg::CH_SEMI) begin
            if (nparams >= NARGS) scan = sgr_pkg::MODE_REGION;
            else begin
               params[nparams] = 0;
               nparams++;
            end
         end else begin
            if (ch == sgr_pkg::CH_M) apply_sgr();
            scan = sgr_pkg::MODE_REGION;
         end
      end else if (ch == sgr_pkg::CH_ESC) scan = sgr_pkg::MODE_ESC;
      if (last) tracker_clear();
   endfunction

   // result side: random stall and scoreboard
   always @(posedge clock) begin
      glyph_type g, e;
      if (!reset) begin
         if (rsp_valid && !rsp_stall) begin
            g = {rsp_out_char, rsp_bold, rsp_italic, rsp_underline, rsp_blink,
                 rsp_inverse, rsp_fg_color, rsp_bg_color};
            if (pending_glyphs.size() == 0) report("unexpected transaction", g.ch, 0);
            else begin
               e = pending_glyphs.pop_front();
               if (g.ch !== e.ch) report("out_char", g.ch, e.ch);
               if (g.bold !== e.bold) report("bold", g.bold, e.bold);
               if (g.italic !== e.italic) report("italic", g.italic, e.italic);
               if (g.underline !== e.underline) report("underline", g.underline, e.underline);
               if (g.blink !== e.blink) report("blink", g.blink, e.blink);
               if (g.inverse !== e.inverse) report("inverse", g.inverse, e.inverse);
               if (g.fg !== e.fg) report("fg_color", g.fg, e.fg);
               if (g.bg !== e.bg) report("bg_color", g.bg, e.bg);
            end
         end
      end
      rsp_stall <= $urandom_range(99) < recv_idle;
   end

   task automatic csr_write(input logic [1:0] idx, input logic [31:0] val);
      csr_psel <= 1'b1; csr_pwrite <= 1'b1; csr_penable <= 1'b0;
      csr_paddr <= {idx, 2'b00}; csr_pwdata <= val;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (!csr_pready) @(posedge clock);
      csr_psel <= 1'b0; csr_penable <= 1'b0; csr_pwrite <= 1'b0;
      if (idx == sgr_pkg::REG_IGNORE) fence_ch = val[20:0];
      else if (idx == sgr_pkg::REG_DEF_FG) dflt_fg = val[8:0];
      else dflt_bg = val[8:0];
   endtask

   // presents one transaction and waits for its acceptance
   task automatic send(input logic [20:0] ch, input logic last);
      while ($urandom_range(99) < send_idle) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1; req_char_code <= ch; req_last_of_prompt <= last;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      track_char(ch, last);
   endtask

   task automatic drain();
      int n;
      req_valid <= 1'b0;
      n = 0;
      while (pending_glyphs.size() != 0 && n < 200000) begin
         @(posedge clock);
         n++;
      end
      // a closing m can start an argument walk with no glyph behind it
      repeat (2 * NARGS + 20) @(posedge clock);
   endtask

   task automatic send_number(input int unsigned v);
      string s;
      s = $sformatf("%0d", v);
      foreach (s[k]) send(21'(s[k]), 1'b0);
   endtask

   function automatic int unsigned pick_arg();
      int r;
      r = $urandom_range(99);
      if (r < 55) return $urandom_range(48);
      if (r < 70) return $urandom_range(65);
      if (r < 80) return $urandom_range(2) == 0 ? 38 : 48;
      if (r < 85) return 5;
      if (r < 90) return $urandom_range(300);
      if (r < 95) return $urandom_range(99999);
      return 2;
   endfunction

   function automatic logic [20:0] pick_char();
      int r;
      r = $urandom_range(9);
      if (r < 6) return 21'($urandom_range(32, 126));
      if (r < 8) return 21'($urandom_range(1, 21'h1FFFFF));
      return 21'($urandom_range(1, 1114111));
   endfunction

   // one random prompt of mixed text and fenced escape regions
   task automatic random_prompt(ref int budget);
      int nseg, na;
      nseg = $urandom_range(1, 6);
      repeat (nseg) begin
         if (fence_ch != 0 && $urandom_range(2) != 0) begin
            send(fence_ch, 1'b0);
            if ($urandom_range(9) == 0) send(pick_char(), 1'b0);
            send(sgr_pkg::CH_ESC, 1'b0);
            if ($urandom_range(9) == 0) send(sgr_pkg::CH_ESC, 1'b0);
            send(sgr_pkg::CH_LBR, 1'b0);
            na = $urandom_range(9) == 0 ? $urandom_range(30, 34) : $urandom_range(1, 6);
            for (int k = 0; k < na; k++) begin
               if (k != 0) send(sgr_pkg::CH_SEMI, 1'b0);
               if ($urandom_range(7) != 0) send_number(pick_arg());
            end
            case ($urandom_range(11))
               0: send(pick_char(), 1'b0);
               1: ;
               default: send(sgr_pkg::CH_M, 1'b0);
            endcase
            if ($urandom_range(7) != 0) send(fence_ch, 1'b0);
            budget -= na * 2 + 4;
         end else begin
            repeat ($urandom_range(1, 5)) send(pick_char(), 1'b0);
            budget -= 3;
         end
      end
      send($urandom_range(1) ? pick_char() : sgr_pkg::CH_ESC, 1'b1);
      budget--;
   endtask

   row_type table_rows[$];

   function automatic row_type mk(input logic [20:0] ch, input logic last, input bit typed,
                                  input logic [4:0] f, input logic [8:0] fg,
                                  input logic [8:0] bg);
      row_type r;
      r.ch = ch; r.last = last; r.typed = typed;
      r.want = {ch, f[0], f[1], f[2], f[3], f[4], fg, bg};
      return r;
   endfunction

   initial begin
      int budget;
      row_type r;
      glyph_type got;
      fence_ch = '0; dflt_fg = 9'h1FF; dflt_bg = 9'h1FF;
      tracker_clear();
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: fence 7, defaults -1
      csr_write(sgr_pkg::REG_IGNORE, 32'd7);
      table_rows.push_back(mk(21'd1, 1'b0, 1, 5'd0, 9'h1FF, 9'h1FF));
      table_rows.push_back(mk(21'h10FFFF, 1'b0, 1, 5'd0, 9'h1FF, 9'h1FF));
      table_rows.push_back(mk(21'h1FFFFF, 1'b0, 1, 5'd0, 9'h1FF, 9'h1FF));
      begin
         logic [20:0] seq[$];
         // bold italic under blink inverse, 38;5;999 clamps, 48;2;r;g;b, then junk stops
         seq = {21'd7, sgr_pkg::CH_ESC, sgr_pkg::CH_LBR, 21'd49, sgr_pkg::CH_SEMI, 21'd51,
                sgr_pkg::CH_SEMI, 21'd52, sgr_pkg::CH_SEMI, 21'd53, sgr_pkg::CH_SEMI, 21'd55,
                sgr_pkg::CH_SEMI, 21'd51, 21'd56, sgr_pkg::CH_SEMI, 21'd53, sgr_pkg::CH_SEMI,
                21'd57, 21'd57, 21'd57, sgr_pkg::CH_SEMI, 21'd52, 21'd56, sgr_pkg::CH_SEMI,
                21'd50, sgr_pkg::CH_SEMI, 21'd57, sgr_pkg::CH_SEMI, 21'd57, sgr_pkg::CH_SEMI,
                21'd57, sgr_pkg::CH_SEMI, 21'd57, 21'd57, sgr_pkg::CH_SEMI, 21'd49, 21'd54,
                sgr_pkg::CH_M, 21'd7};
         foreach (seq[k]) table_rows.push_back(mk(seq[k], 1'b0, 0, 0, 0, 0));
      end
      table_rows.push_back(mk(21'd66, 1'b1, 1, 5'h1F, 9'd255, 9'd1));
      table_rows.push_back(mk(21'd67, 1'b0, 1, 5'd0, 9'h1FF, 9'h1FF));
      foreach (table_rows[k]) begin
         r = table_rows[k];
         send(r.ch, r.last);
         if (r.typed) begin
            got = pending_glyphs[$];
            if (got !== r.want) report("directed row", k, 0);
         end
      end
      drain();

      // directed: zero fence lets character 0 through, extreme defaults
      csr_write(sgr_pkg::REG_IGNORE, 32'd0);
      csr_write(sgr_pkg::REG_DEF_FG, 32'd255);
      csr_write(sgr_pkg::REG_DEF_BG, 32'd0);
      send(21'd0, 1'b1);
      send(sgr_pkg::CH_ESC, 1'b0);
      send(21'd90, 1'b1);
      drain();

      // random phases across idling mixes and register settings
      for (int ph = 0; ph < 8; ph++) begin
         case (ph % 4)
            0: begin send_idle = 0; recv_idle = 0; end
            1: begin send_idle = 48; recv_idle = 0; end
            2: begin send_idle = 0; recv_idle = 48; end
            default: begin send_idle = 27; recv_idle = 27; end
         endcase
         csr_write(sgr_pkg::REG_IGNORE,
                   ph == 7 ? 32'h1FFFFF : (ph == 3 ? 32'd0 : 32'd30 + ph));
         csr_write(sgr_pkg::REG_DEF_FG, ph == 5 ? 32'h1FF : 32'($urandom_range(256)));
         csr_write(sgr_pkg::REG_DEF_BG, ph == 6 ? 32'd255 : 32'($urandom_range(511)));
         budget = N_RANDOM / 8;
         while (budget > 0) random_prompt(budget);
         drain();
      end

      if (errors == 0) $display("sgr_escape_attribute_tracker regression: pass");
      else $display("sgr_escape_attribute_tracker regression: fail");
      $finish;
   end
endmodule
`default_nettype wire
